### hdl/versioned_domain_id_allocator_core_defines.svh
// Assertion macros used by the domain id allocator core.
`ifndef VERSIONED_DOMAIN_ID_ALLOCATOR_CORE_DEFINES_SVH
`define VERSIONED_DOMAIN_ID_ALLOCATOR_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VDIA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define VDIA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/vdia_pkg.sv
// Types, constants and helper functions of the domain id allocator.
`timescale 1ns / 1ps

package vdia_pkg;

   // Table geometry.
   localparam int SLOT_COUNT     = 1024;
   localparam int FIRST_ORDINARY = 16;
   localparam int MAX_VERSION    = 1023;

   // Fixed field widths of the request and response.
   localparam int ID_W     = 10;
   localparam int VER_W    = 10;
   localparam int TASK_W   = 11;
   localparam int STATUS_W = 3;
   localparam int CMP_W    = 12;

   localparam int TASK_MASK = (1 << 11) - 1;
   localparam int VLOW_MASK = (1 << 10) - 1;

   // The free bitmap is held as words of 32 slots each.
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;
   localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SLOT_W     = WIDX_W + BIT_W;
   localparam int VER_AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [1:0] {
      MODE_ANY   = 2'd0,
      MODE_NAMED = 2'd1,
      MODE_FREE  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_GRANTED      = 3'd0,
      STAT_EXHAUSTED    = 3'd1,
      STAT_REFUSED      = 3'd2,
      STAT_FREED        = 3'd3,
      STAT_ALREADY_FREE = 3'd4,
      STAT_RETIRED      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR = 3'd0,
      FSM_IDLE  = 3'd1,
      FSM_MAP   = 3'd2,
      FSM_VER   = 3'd3,
      FSM_REPLY = 3'd4
   } fsm_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     slot;
      logic [TASK_W-1:0]   task_num;
      logic [VER_W-1:0]    version;
   } result_type;

   // Bits of a bitmap word that stand for slots that exist.
   function automatic word_type live_mask(input logic [WIDX_W-1:0] w);
      word_type m;
      int       idx;
      m = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         idx  = int'(w) * WORD_BITS + j;
         m[j] = (idx < SLOT_COUNT);
      end
      return m;
   endfunction

   // Bits of a bitmap word that allocate-any may hand out.
   function automatic word_type ordinary_mask(input logic [WIDX_W-1:0] w);
      word_type m;
      int       idx;
      m = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         idx  = int'(w) * WORD_BITS + j;
         m[j] = (idx >= FIRST_ORDINARY) && (idx < SLOT_COUNT);
      end
      return m;
   endfunction

   // Summary bits after reset: a word is marked when it holds an ordinary slot.
   function automatic logic [WORD_COUNT-1:0] summary_init();
      logic [WORD_COUNT-1:0] s;
      s = '0;
      for (int w = 0; w < WORD_COUNT; w++) begin
         s[w] = |ordinary_mask(WIDX_W'(w));
      end
      return s;
   endfunction

   // Index of the lowest set bit of a bitmap word.
   function automatic logic [BIT_W-1:0] lowest_bit(input word_type v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (v[j]) begin
            r = BIT_W'(j);
         end
      end
      return r;
   endfunction

   // Index of the lowest set bit of the summary vector.
   function automatic logic [WIDX_W-1:0] lowest_word(input logic [WORD_COUNT-1:0] v);
      logic [WIDX_W-1:0] r;
      r = '0;
      for (int j = WORD_COUNT - 1; j >= 0; j--) begin
         if (v[j]) begin
            r = WIDX_W'(j);
         end
      end
      return r;
   endfunction

endpackage

### hdl/versioned_domain_id_allocator_core.sv
// Top level of the versioned domain id allocator.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   mode, slot_id
//   rsp_      out        rsp_valid/rsp_ready   status, granted_slot, slot_version,
//                                              task_number, version_tag
//
// A request that needs the tables passes the bitmap word read, the version read and
// decide and write back before its reply stage; the next request can transfer once
// the block is back in idle. One that is settled from the request alone (out of range,
// unused mode, named slot not reserved, exhausted) goes straight to its reply stage.
// Requests are handled one at a time through the single port of each memory.
// After reset a clearing pass steps through every slot, writing every version to zero
// and the free bitmap to all free; no request is taken meanwhile.
// A stalled response sits in the output register while the next request runs;
// that request then waits in its reply stage until the response is taken.
`timescale 1ns / 1ps
`include "versioned_domain_id_allocator_core_defines.svh"

module versioned_domain_id_allocator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_mode,
   input  logic [vdia_pkg::ID_W-1:0]      req_slot_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [vdia_pkg::STATUS_W-1:0]  rsp_status,
   output logic [vdia_pkg::ID_W-1:0]      rsp_granted_slot,
   output logic [vdia_pkg::VER_W-1:0]     rsp_slot_version,
   output logic [vdia_pkg::TASK_W-1:0]    rsp_task_number,
   output logic [vdia_pkg::VER_W-1:0]     rsp_version_tag
);
   import vdia_pkg::*;

   // Control and request registers.
   fsm_type                state_ff, state_in;
   logic [VER_AW-1:0]      clr_ff, clr_in;
   logic [1:0]             mode_ff, mode_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [WORD_COUNT-1:0]  summary_ff, summary_in;
   result_type             res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   // Free bitmap memory and version memory.
   word_type               map_mem [WORD_COUNT];
   logic [VER_W-1:0]       ver_mem [SLOT_COUNT];

   logic                   map_rd_en;
   logic [WIDX_W-1:0]      map_raddr;
   word_type               map_rdata_ff;
   logic                   map_we;
   logic [WIDX_W-1:0]      map_waddr;
   word_type               map_wdata;

   logic                   ver_rd_en;
   logic [VER_AW-1:0]      ver_raddr;
   logic [VER_W-1:0]       ver_rdata_ff;
   logic                   ver_we;
   logic [VER_AW-1:0]      ver_waddr;
   logic [VER_W-1:0]       ver_wdata;

   // Helpers for the request and the slot under work.
   logic [CMP_W-1:0]       req_cmp;
   logic                   id_in_range;
   logic                   id_ordinary;
   logic [SLOT_W-1:0]      req_slot;
   logic [WIDX_W-1:0]      cur_word;
   logic [BIT_W-1:0]       cur_bit;
   logic [SLOT_W-1:0]      any_slot;
   logic                   cur_free;
   word_type               new_word;
   result_type             refuse_res;

   assign req_cmp     = CMP_W'(req_slot_id);
   assign id_in_range = (req_cmp < CMP_W'(SLOT_COUNT));
   assign id_ordinary = (req_cmp >= CMP_W'(FIRST_ORDINARY));
   assign req_slot    = SLOT_W'(req_slot_id);
   assign cur_word    = slot_ff[SLOT_W-1:BIT_W];
   assign cur_bit     = slot_ff[BIT_W-1:0];
   assign any_slot    = {cur_word, lowest_bit(map_rdata_ff & ordinary_mask(cur_word))};
   assign cur_free    = map_rdata_ff[cur_bit];

   // Next state, memory accesses and result formation.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      summary_in   = summary_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      map_rd_en    = 1'b0;
      map_raddr    = cur_word;
      map_we       = 1'b0;
      map_waddr    = cur_word;
      map_wdata    = map_rdata_ff;
      ver_rd_en    = 1'b0;
      ver_raddr    = slot_ff[VER_AW-1:0];
      ver_we       = 1'b0;
      ver_waddr    = slot_ff[VER_AW-1:0];
      ver_wdata    = ver_rdata_ff;
      new_word     = map_rdata_ff;
      req_ready    = (state_ff == FSM_IDLE);

      refuse_res          = '0;
      refuse_res.status   = STAT_REFUSED;
      refuse_res.slot     = req_slot_id;

      // The output register empties on a transfer.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         FSM_CLEAR: begin
            ver_we    = 1'b1;
            ver_waddr = clr_ff;
            ver_wdata = '0;
            if (int'(clr_ff) < WORD_COUNT) begin
               map_we    = 1'b1;
               map_waddr = WIDX_W'(clr_ff);
               map_wdata = live_mask(WIDX_W'(clr_ff));
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == VER_AW'(SLOT_COUNT - 1)) begin
               state_in = FSM_IDLE;
            end
         end

         FSM_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               id_in   = req_slot_id;
               case (req_mode)
                  MODE_ANY: begin
                     if (summary_ff == '0) begin
                        res_in        = '0;
                        res_in.status = STAT_EXHAUSTED;
                        state_in      = FSM_REPLY;
                     end else begin
                        map_rd_en = 1'b1;
                        map_raddr = lowest_word(summary_ff);
                        slot_in   = {lowest_word(summary_ff), BIT_W'(0)};
                        state_in  = FSM_MAP;
                     end
                  end
                  MODE_NAMED: begin
                     if (!id_in_range || id_ordinary) begin
                        res_in   = refuse_res;
                        state_in = FSM_REPLY;
                     end else begin
                        map_rd_en = 1'b1;
                        map_raddr = req_slot[SLOT_W-1:BIT_W];
                        slot_in   = req_slot;
                        state_in  = FSM_MAP;
                     end
                  end
                  MODE_FREE: begin
                     if (!id_in_range) begin
                        res_in   = refuse_res;
                        state_in = FSM_REPLY;
                     end else begin
                        map_rd_en = 1'b1;
                        map_raddr = req_slot[SLOT_W-1:BIT_W];
                        slot_in   = req_slot;
                        state_in  = FSM_MAP;
                     end
                  end
                  default: begin
                     res_in   = refuse_res;
                     state_in = FSM_REPLY;
                  end
               endcase
            end
         end

         // The bitmap word is in; allocate-any picks its slot here.
         FSM_MAP: begin
            ver_rd_en = 1'b1;
            if (mode_ff == MODE_ANY) begin
               slot_in   = any_slot;
               ver_raddr = any_slot[VER_AW-1:0];
            end
            state_in = FSM_VER;
         end

         // Both words are in: decide, write back and form the result.
         FSM_VER: begin
            state_in      = FSM_REPLY;
            res_in        = '0;
            res_in.slot   = id_ff;
            if (mode_ff == MODE_FREE) begin
               if (cur_free) begin
                  res_in.status = STAT_ALREADY_FREE;
               end else if (ver_rdata_ff >= VER_W'(MAX_VERSION)) begin
                  res_in.status = STAT_RETIRED;
               end else begin
                  new_word   = map_rdata_ff | (word_type'(1) << cur_bit);
                  map_we     = 1'b1;
                  map_wdata  = new_word;
                  ver_we     = 1'b1;
                  ver_wdata  = ver_rdata_ff + 1'b1;
                  summary_in[cur_word] = |(new_word & ordinary_mask(cur_word));
                  res_in.status = STAT_FREED;
               end
            end else if (!cur_free) begin
               res_in.status = STAT_REFUSED;
            end else begin
               new_word        = map_rdata_ff & ~(word_type'(1) << cur_bit);
               map_we          = 1'b1;
               map_wdata       = new_word;
               summary_in[cur_word] = |(new_word & ordinary_mask(cur_word));
               res_in.status   = STAT_GRANTED;
               res_in.slot     = ID_W'(slot_ff);
               res_in.task_num = TASK_W'(slot_ff) & TASK_W'(TASK_MASK);
               res_in.version  = ver_rdata_ff & VER_W'(VLOW_MASK);
            end
         end

         // Hand the result to the output register once it is free.
         FSM_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_ff       <= '0;
         summary_ff   <= summary_init();
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      id_ff   <= id_in;
      slot_ff <= slot_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // Free bitmap memory.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      if (map_rd_en) begin
         map_rdata_ff <= map_mem[map_raddr];
      end
   end

   // Version memory.
   always_ff @(posedge clock) begin
      if (ver_we) begin
         ver_mem[ver_waddr] <= ver_wdata;
      end
      if (ver_rd_en) begin
         ver_rdata_ff <= ver_mem[ver_raddr];
      end
   end

   // Response ports.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_granted_slot = rsp_ff.slot;
   assign rsp_slot_version = rsp_ff.version;
   assign rsp_task_number  = rsp_ff.task_num;
   assign rsp_version_tag  = rsp_ff.version;

   // Only one request is in work at a time.
   `VDIA_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready, "second request taken while busy")
   // A grant carries the same slot and version in both of its forms.
   `VDIA_ASSERT_NOW(a_grant_fields, rsp_valid && (rsp_status == STAT_GRANTED), (rsp_task_number[9:0] == rsp_granted_slot) && (rsp_slot_version == rsp_version_tag), "granted fields disagree")
   // Anything but a grant carries no version and no task number.
   `VDIA_ASSERT_NOW(a_other_zero, rsp_valid && (rsp_status != STAT_GRANTED), (rsp_slot_version == '0) && (rsp_task_number == '0), "non-grant carries grant fields")

endmodule

### tb/slot_reply_checker.sv
// Checker that predicts every allocator reply and compares it with the reply the block sends.
`timescale 1ns / 1ps

module slot_reply_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [vdia_pkg::ID_W-1:0]     req_slot_id,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [vdia_pkg::STATUS_W-1:0] rsp_status,
   input  logic [vdia_pkg::ID_W-1:0]     rsp_granted_slot,
   input  logic [vdia_pkg::VER_W-1:0]    rsp_slot_version,
   input  logic [vdia_pkg::TASK_W-1:0]   rsp_task_number,
   input  logic [vdia_pkg::VER_W-1:0]    rsp_version_tag,
   output int                            fail_count,
   output int                            pending_count
);
   import vdia_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   slot;
      logic [VER_W-1:0]  version;
      logic [TASK_W-1:0] task_num;
      logic [VER_W-1:0]  version_tag;
   } slot_reply_type;

   // Predicted copy of the slot table.
   logic [SLOT_COUNT-1:0] slot_reserved;
   logic [SLOT_COUNT-1:0] slot_free;
   logic [VER_W-1:0]      slot_ver [SLOT_COUNT];

   // Replies owed by the block, oldest first.
   slot_reply_type replies_due [$];
   int             mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   // Applies one request to the predicted table and works out its reply.
   task automatic serve_request(input logic [1:0] mode, input logic [ID_W-1:0] id,
                                output slot_reply_type reply);
      int pick;
      reply      = '0;
      reply.slot = id;
      pick       = -1;
      case (mode)
         MODE_ANY: begin
            // Lowest free slot among the ordinary ones.
            for (int s = SLOT_COUNT - 1; s >= FIRST_ORDINARY; s--) begin
               if (slot_free[s]) begin
                  pick = s;
               end
            end
            reply.slot   = '0;
            reply.status = STAT_EXHAUSTED;
         end
         MODE_NAMED: begin
            reply.status = STAT_REFUSED;
            if (int'(id) < SLOT_COUNT && slot_reserved[id] && slot_free[id]) begin
               pick = int'(id);
            end
         end
         MODE_FREE: begin
            if (int'(id) >= SLOT_COUNT) begin
               reply.status = STAT_REFUSED;
            end else if (slot_free[id]) begin
               reply.status = STAT_ALREADY_FREE;
            end else if (int'(slot_ver[id]) >= MAX_VERSION) begin
               // The slot stays in use for good once its version is spent.
               reply.status = STAT_RETIRED;
            end else begin
               slot_free[id] = 1'b1;
               slot_ver[id]  = slot_ver[id] + 1'b1;
               reply.status  = STAT_FREED;
            end
         end
         default: begin
            reply.status = STAT_REFUSED;
         end
      endcase
      // Both allocate modes finish here when they found a slot.
      if (pick >= 0) begin
         slot_free[pick]   = 1'b0;
         reply.status      = STAT_GRANTED;
         reply.slot        = ID_W'(pick);
         reply.version     = slot_ver[pick];
         reply.task_num    = TASK_W'(pick) & TASK_W'(TASK_MASK);
         reply.version_tag = slot_ver[pick] & VER_W'(VLOW_MASK);
      end
   endtask

   always @(posedge clock) begin
      slot_reply_type want;
      slot_reply_type fresh;
      if (reset) begin
         for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_reserved[s] = (s < FIRST_ORDINARY);
            slot_free[s]     = 1'b1;
            slot_ver[s]      = '0;
         end
         replies_due.delete();
      end else begin
         // A reply transfer is held against the oldest prediction.
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("reply transfer with no request outstanding");
            end else begin
               want = replies_due.pop_front();
               compare_field("status", 16'(rsp_status), 16'(want.status));
               compare_field("granted_slot", 16'(rsp_granted_slot), 16'(want.slot));
               compare_field("slot_version", 16'(rsp_slot_version), 16'(want.version));
               compare_field("task_number", 16'(rsp_task_number), 16'(want.task_num));
               compare_field("version_tag", 16'(rsp_version_tag), 16'(want.version_tag));
            end
         end
         // A request transfer updates the table and queues its reply.
         if (req_valid && req_ready) begin
            serve_request(req_mode, req_slot_id, fresh);
            replies_due.push_back(fresh);
         end
      end
      pending_count <= replies_due.size();
   end

endmodule

### tb/tb.sv
// Top of the allocator testbench: clock, reset, request and reply traffic, and the verdict.
`timescale 1ns / 1ps

module tb;
   import vdia_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int RESET_CYCLES   = 11;
   localparam int STALL_LIMIT    = 4000;
   localparam int FILL_ITEMS     = 1015;
   localparam int RANDOM_ITEMS   = 760;
   localparam int LONG_HOLD      = 120;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_mode;
   logic [ID_W-1:0]     req_slot_id;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_granted_slot;
   logic [VER_W-1:0]    rsp_slot_version;
   logic [TASK_W-1:0]   rsp_task_number;
   logic [VER_W-1:0]    rsp_version_tag;
   int                  fail_count;
   int                  pending_count;
   int                  sent_total   = 0;
   int                  stall_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   versioned_domain_id_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_slot_id      (req_slot_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_slot_version (rsp_slot_version),
      .rsp_task_number  (rsp_task_number),
      .rsp_version_tag  (rsp_version_tag)
   );

   slot_reply_checker reply_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_slot_id      (req_slot_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_slot_version (rsp_slot_version),
      .rsp_task_number  (rsp_task_number),
      .rsp_version_tag  (rsp_version_tag),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Offers one request after a random gap, or back to back in some stretches, and returns once it is transferred.
   task automatic offer_request(input logic [1:0] mode, input logic [ID_W-1:0] id);
      int gap;
      if ((sent_total / 150) % 5 == 3) begin
         gap = 0;
      end else begin
         gap = $urandom_range(0, 5);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_slot_id <= id;
      do @(posedge clock); while (!req_ready);
      sent_total++;
   endtask

   // Holds off new requests until every predicted reply has come back.
   task automatic wait_for_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Reply side: a random stall after each transfer, quiet stretches, two long holds.
   initial begin : reply_drain
      int hold;
      int seen;
      hold = 0;
      seen = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            seen++;
            if (seen == 600 || seen == 1400) begin
               hold = LONG_HOLD;
            end else if ((seen / 200) % 5 == 1) begin
               hold = 0;
            end else begin
               hold = $urandom_range(0, 5);
            end
         end else if (hold > 0) begin
            hold--;
         end
         rsp_ready <= (hold == 0);
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int pick;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_mode    <= MODE_ANY;
      req_slot_id <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: every mode, both ends of the id range, reserved slots.
      offer_request(MODE_ANY, '0);
      offer_request(MODE_ANY, '1);
      offer_request(MODE_NAMED, ID_W'(0));
      offer_request(MODE_NAMED, ID_W'(0));
      offer_request(MODE_NAMED, ID_W'(FIRST_ORDINARY - 1));
      offer_request(MODE_NAMED, ID_W'(FIRST_ORDINARY));
      offer_request(MODE_NAMED, '1);
      offer_request(MODE_NAMED, 10'h2AA);
      offer_request(MODE_FREE, ID_W'(FIRST_ORDINARY));
      offer_request(MODE_FREE, ID_W'(FIRST_ORDINARY));
      offer_request(MODE_ANY, 10'h155);
      offer_request(MODE_FREE, ID_W'(0));
      offer_request(MODE_NAMED, ID_W'(0));
      offer_request(MODE_FREE, '1);
      offer_request(MODE_FREE, 10'h155);
      offer_request(MODE_UNUSED, '0);
      offer_request(MODE_UNUSED, '1);
      offer_request(MODE_FREE, ID_W'(FIRST_ORDINARY - 1));
      offer_request(MODE_FREE, ID_W'(FIRST_ORDINARY + 1));
      offer_request(MODE_ANY, 10'h2AA);
      offer_request(MODE_NAMED, ID_W'(FIRST_ORDINARY - 1));
      wait_for_replies();

      // Take every ordinary slot until the table reports exhausted.
      for (int n = 0; n < FILL_ITEMS; n++) begin
         offer_request(MODE_ANY, ID_W'($urandom));
      end
      offer_request(MODE_FREE, ID_W'(SLOT_COUNT - 1));
      offer_request(MODE_ANY, '1);
      offer_request(MODE_ANY, '0);
      wait_for_replies();

      // Random traffic; frees aim mostly at the low slots that allocation keeps reusing.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            offer_request(MODE_ANY, ID_W'($urandom));
         end else if (pick < 50) begin
            if ($urandom_range(0, 3) != 0) begin
               offer_request(MODE_NAMED, ID_W'($urandom_range(0, FIRST_ORDINARY - 1)));
            end else begin
               offer_request(MODE_NAMED, ID_W'($urandom));
            end
         end else if (pick < 93) begin
            if ($urandom_range(0, 9) < 7) begin
               offer_request(MODE_FREE, ID_W'($urandom_range(0, 127)));
            end else begin
               offer_request(MODE_FREE, ID_W'($urandom));
            end
         end else begin
            offer_request(MODE_UNUSED, ID_W'($urandom));
         end
      end
      wait_for_replies();
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/vdia_pkg.sv
hdl/versioned_domain_id_allocator_core.sv
tb/slot_reply_checker.sv
tb/tb.sv
